FILE: hdl/lru_key_value_cache_assert.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LKV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru cache assertion failed");

// Next-cycle implication, checked outside reset.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru cache assertion failed");

`endif

FILE: hdl/lkv_pkg.sv
// Shared constants and control types for the LRU key/value cache.
package lkv_pkg;

    // Storage geometry
    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Port field widths
    localparam int KEY_FIELD_W   = 16;
    localparam int VALUE_FIELD_W = 32;
    localparam int READ_FIELD_W  = 32;
    localparam int CAP_W         = 5;
    localparam int S_TDATA_W     = ((KEY_FIELD_W + VALUE_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((READ_FIELD_W + 7) / 8) * 8;

    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request kinds
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // latch the request beat
        logic lookup;   // compare keys, pick target, read value
        logic commit;   // update store, form result
        logic load;     // move result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } t_status;

endpackage

FILE: hdl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// Usage:
//   Requests arrive on the s_axis channel, one beat per request: tuser[0] is
//   the action (0 get, 1 put), tdata carries the key and the put value.
//   Every request yields exactly one result beat on m_axis: tuser[0] is the
//   hit flag (key present before the request), tdata the stored value on a
//   get hit and zero otherwise.
//   The capacity register (entries held before eviction) is written through
//   the cfg channel, which is always ready; write it only while idle.
// Timing:
//   A result enters the output register after its request beat is accepted,
//   through tag compare with value RAM read, store update and result load.
//   s_axis_tready is high only while the controller is idle, so a new
//   request is not taken until the previous one has been loaded as a result,
//   as set by the controller's sequence and the registered value RAM read.
// Reset:
//   All entries invalid, occupancy zero, capacity 16, no result pending.
// Stalls:
//   A result waits in the output register while m_axis_tready is low; the
//   next request is still accepted and processed up to its result load.
module lru_key_value_cache (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request: tdata = {value[31:0], key[15:0]} from bit 0 up; tuser = {action}
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lkv_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [0:0]                      s_axis_tuser,
    // result: tdata = {read_value[31:0]}; tuser = {hit}
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lkv_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic [0:0]                      m_axis_tuser,
    // capacity register write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]       i_cfg_data
);

    localparam int KF = lkv_pkg::KEY_FIELD_W;
    localparam int VF = lkv_pkg::VALUE_FIELD_W;
    localparam int RF = lkv_pkg::READ_FIELD_W;

    lkv_pkg::t_cmd    cmd;
    lkv_pkg::t_status status;
    logic             out_hit;
    logic [RF-1:0]    out_value;
    logic [lkv_pkg::M_TDATA_W+RF-1:0] out_ext;

    assign o_cfg_ready = 1'b1;

    lkv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lkv_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_action    (s_axis_tuser[0]),
        .i_key       (s_axis_tdata[KF-1:0]),
        .i_value     (s_axis_tdata[KF+VF-1:KF]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_hit   (out_hit),
        .o_out_value (out_value)
    );

    // Output packing, zero filled to whole bytes
    assign out_ext         = {{lkv_pkg::M_TDATA_W{1'b0}}, out_value};
    assign m_axis_tdata    = out_ext[lkv_pkg::M_TDATA_W-1:0];
    assign m_axis_tuser[0] = out_hit;

`include "lru_key_value_cache_assert.svh"

    // one request in flight: no new beat right after one is taken
    `LKV_ASSERT_NEXT(a_single_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a result is never loaded over one still waiting downstream
    `LKV_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.load, status.out_free)
    // controller issues at most one step per cycle
    `LKV_ASSERT_NOW(a_one_step, i_clk, i_rst_n, 1'b1, $onehot0(cmd))
    // a loaded result shows on the output in the next cycle
    `LKV_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, cmd.load, m_axis_tvalid)

endmodule

FILE: hdl/lkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lkv_datapath.sv
// Datapath: key tags, recency ranks, value RAM, capacity register, output register.
module lkv_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lkv_pkg::t_cmd                      i_cmd,
    output lkv_pkg::t_status                   o_status,
    // request fields
    input  logic                               i_action,
    input  logic [lkv_pkg::KEY_FIELD_W-1:0]    i_key,
    input  logic [lkv_pkg::VALUE_FIELD_W-1:0]  i_value,
    // capacity register write
    input  logic                               i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]          i_cfg_data,
    // result
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_out_hit,
    output logic [lkv_pkg::READ_FIELD_W-1:0]   o_out_value
);

    localparam int N   = lkv_pkg::ENTRIES;
    localparam int IW  = lkv_pkg::IDX_W;
    localparam int CW  = lkv_pkg::CNT_W;
    localparam int KB  = lkv_pkg::KEY_BITS;
    localparam int VB  = lkv_pkg::VALUE_BITS;
    localparam int KF  = lkv_pkg::KEY_FIELD_W;
    localparam int VF  = lkv_pkg::VALUE_FIELD_W;
    localparam int RF  = lkv_pkg::READ_FIELD_W;
    localparam int MW  = lkv_pkg::CMP_W;

    typedef enum logic [1:0] {
        M_NONE,     // get miss: store untouched
        M_PROMOTE,  // hit or eviction: target moves to most recent
        M_INSERT    // fill a free slot: all valid entries age
    } t_mode;

    // Entry state
    logic [N-1:0]       r_valid;
    logic [KB-1:0]      r_key   [N];
    logic [IW-1:0]      r_rank  [N];
    logic [CW-1:0]      r_occ;
    logic [lkv_pkg::CAP_W-1:0] r_cap;

    // Request latch
    logic               r_in_act;
    logic [KB-1:0]      r_in_key;
    logic [VB-1:0]      r_in_val;

    // Lookup results
    logic               r_hit;
    logic [IW-1:0]      r_tgt;
    t_mode              r_mode;
    logic               r_wr_key;

    // Result and output register
    logic               r_res_hit;
    logic [RF-1:0]      r_res_val;
    logic               r_out_valid;
    logic               r_out_hit;
    logic [RF-1:0]      r_out_val;

    // Width adaption of request fields and read data
    logic [KF+KB-1:0]   key_ext;
    logic [VF+VB-1:0]   val_ext;
    logic [RF+VB-1:0]   rd_ext;
    logic [VB-1:0]      ram_rdata;
    logic               ram_we;

    // Lookup combinational
    logic [N-1:0]       match;
    logic               hit_any;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      free_idx;
    logic [IW-1:0]      victim_idx;
    logic [CW-1:0]      occ_m1;
    logic [MW-1:0]      cap_x;
    logic [MW-1:0]      cap_eff;
    logic               evict;

    assign key_ext = {{KB{1'b0}}, i_key};
    assign val_ext = {{VB{1'b0}}, i_value};
    assign rd_ext  = {{RF{1'b0}}, ram_rdata};

    // Capacity clamp and search over the tags
    always_comb begin
        cap_x = MW'(r_cap);
        if (cap_x == '0) begin
            cap_eff = MW'(1);
        end else if (cap_x > MW'(N)) begin
            cap_eff = MW'(N);
        end else begin
            cap_eff = cap_x;
        end
        evict  = (MW'(r_occ) >= cap_eff);
        occ_m1 = r_occ - CW'(1);

        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_key[i] == r_in_key);
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
            // ranks of valid entries form 0..occ-1, so the oldest is unique
            if (r_valid[i] && (r_rank[i] == occ_m1[IW-1:0])) begin
                victim_idx = IW'(i);
            end
        end
        hit_any = |match;
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkv_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_act <= i_action;
            r_in_key <= key_ext[KB-1:0];
            r_in_val <= val_ext[VB-1:0];
        end
    end

    // Lookup stage registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit <= hit_any;
            if (hit_any) begin
                r_tgt    <= hit_idx;
                r_mode   <= M_PROMOTE;
                r_wr_key <= 1'b0;
            end else if (r_in_act == lkv_pkg::ACT_GET) begin
                r_tgt    <= hit_idx;
                r_mode   <= M_NONE;
                r_wr_key <= 1'b0;
            end else if (evict) begin
                r_tgt    <= victim_idx;
                r_mode   <= M_PROMOTE;
                r_wr_key <= 1'b1;
            end else begin
                r_tgt    <= free_idx;
                r_mode   <= M_INSERT;
                r_wr_key <= 1'b1;
            end
        end
    end

    // Store update: valid bits, ranks, occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit && (r_mode != M_NONE)) begin
            for (int i = 0; i < N; i++) begin
                if (IW'(i) == r_tgt) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] &&
                             ((r_mode == M_INSERT) || (r_rank[i] < r_rank[r_tgt]))) begin
                    r_rank[i] <= r_rank[i] + IW'(1);
                end
            end
            if (r_mode == M_INSERT) begin
                r_valid[r_tgt] <= 1'b1;
                r_occ          <= r_occ + CW'(1);
            end
        end
    end

    // Key tags need no reset: read only where valid
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_wr_key) begin
            r_key[r_tgt] <= r_in_key;
        end
    end

    // Value store
    assign ram_we = i_cmd.commit && (r_mode != M_NONE) && (r_in_act == lkv_pkg::ACT_PUT);

    lkv_ram #(
        .WIDTH (VB),
        .DEPTH (N)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tgt),
        .i_wdata (r_in_val),
        .i_re    (i_cmd.lookup),
        .i_raddr (hit_idx),
        .o_rdata (ram_rdata)
    );

    // Result: value only on a get hit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_hit <= r_hit;
            r_res_val <= (r_hit && (r_in_act == lkv_pkg::ACT_GET)) ? rd_ext[RF-1:0] : '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_hit <= r_res_hit;
            r_out_val <= r_res_val;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_hit         = r_out_hit;
    assign o_out_value       = r_out_val;

endmodule

FILE: hdl/lkv_ctrl.sv
// Controller: sequences accept, lookup, commit and result load for one request.
module lkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lkv_pkg::t_status  i_status,
    output lkv_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_COMMIT,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Commands follow the state
    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        n_state      = r_state;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_COMMIT;
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                // wait here while the previous result is still held downstream
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
